@@ hdl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/hpc_pkg.sv @@
// types and constants of the heightfield point classifier
`timescale 1ns / 1ps

package hpc_pkg;

  localparam int GRID_W   = 9;
  localparam int SCALE_W  = 32;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int PROD_W   = 66;
  localparam int OPND_W   = 33;

  localparam logic [GRID_W-1:0]  GRID_SIDE_RST    = 9'd256;
  localparam logic [SCALE_W-1:0] RECIP_GRID_RST   = 32'd1024;
  localparam logic [SCALE_W-1:0] RECIP_HEIGHT_RST = 32'd1048576;

  localparam logic [1:0] CONT_EMPTY = 2'd0;
  localparam logic [1:0] CONT_SOLID = 2'd1;
  localparam logic [1:0] CONT_SKY   = 2'd2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic signed [PROD_W-1:0] NEG_ONE_Q24 = -66'sd16777216;
  localparam logic signed [PROD_W-1:0] SKY_LIM_Q24 = 66'sd65535 <<< 24;
  localparam logic signed [PROD_W-1:0] FAR_LIM_Q24 = 66'sd65599 <<< 24;

  typedef enum logic [1:0] {
    REG_GRID_SIDE    = 2'd0,
    REG_RECIP_GRID   = 2'd1,
    REG_RECIP_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [GRID_W-1:0]  grid_side;
    logic [SCALE_W-1:0] recip_grid;
    logic [SCALE_W-1:0] recip_height;
  } cfg_t;

endpackage

@@ hdl/hpc_ram.sv @@
// generic single-write single-read ram with registered read
`timescale 1ns / 1ps

module hpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/hpc_mul.sv @@
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module hpc_mul (
  input  logic                          clk,
  input  logic signed [hpc_pkg::OPND_W-1:0] a,
  input  logic signed [hpc_pkg::OPND_W-1:0] b,
  output logic signed [hpc_pkg::PROD_W-1:0] prod
);
  import hpc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ hdl/hpc_regs.sv @@
// apb configuration registers
`timescale 1ns / 1ps

module hpc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hpc_pkg::PADDR_W-1:0]  paddr,
  input  logic [hpc_pkg::PDATA_W-1:0]  pwdata,
  output logic [hpc_pkg::PDATA_W-1:0]  prdata,
  output hpc_pkg::cfg_t                cfg
);
  import hpc_pkg::*;

  logic wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_side    <= GRID_SIDE_RST;
      cfg.recip_grid   <= RECIP_GRID_RST;
      cfg.recip_height <= RECIP_HEIGHT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_GRID_SIDE:    cfg.grid_side    <= pwdata[GRID_W-1:0];
        REG_RECIP_GRID:   cfg.recip_grid   <= pwdata;
        REG_RECIP_HEIGHT: cfg.recip_height <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GRID_SIDE:    prdata = PDATA_W'(cfg.grid_side);
      REG_RECIP_GRID:   prdata = cfg.recip_grid;
      REG_RECIP_HEIGHT: prdata = cfg.recip_height;
      default:          prdata = '0;
    endcase
  end

endmodule

@@ hdl/heightfield_point_classifier_unit.sv @@
// heightfield point classifier top level: sequencer around one shared multiplier
//
//   channel   handshake                      payload
//   config    psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//   item in   start && !busy                 opcode, entry_index, entry_height,
//                                            pos_x, pos_y, pos_z, clip_offset
//   result    done (one-cycle strobe)        contents
//
// a height write gives no result
// a query is decided by the range checks, else by the interpolated table height
// it uses the single multiplier (scale x, y, z, row offset, three weights) and the
// single table read port in turn
// synchronous active-high reset clears control and config; the table is not cleared
// the receiver cannot stall: done pulses once as busy falls
`timescale 1ns / 1ps
`include "assert_macros.svh"

module heightfield_point_classifier_unit #(
  parameter int MAX_SIDE = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hpc_pkg::PADDR_W-1:0]  paddr,
  input  logic [hpc_pkg::PDATA_W-1:0]  pwdata,
  output logic [hpc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode,
  input  logic [15:0]                  entry_index,
  input  logic [15:0]                  entry_height,
  input  logic signed [31:0]           pos_x,
  input  logic signed [31:0]           pos_y,
  input  logic signed [31:0]           pos_z,
  input  logic signed [31:0]           clip_offset,
  output logic                         done,
  output logic [1:0]                   contents
);
  import hpc_pkg::*;

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = (SIDE_W > GRID_W) ? SIDE_W : GRID_W;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_MX   = 11'b00000000010,
    S_MY   = 11'b00000000100,
    S_MZ   = 11'b00000001000,
    S_CHK  = 11'b00000010000,
    S_ROW  = 11'b00000100000,
    S_RD0  = 11'b00001000000,
    S_M0   = 11'b00010000000,
    S_M1   = 11'b00100000000,
    S_M2   = 11'b01000000000,
    S_CMP  = 11'b10000000000
  } state_t;

  state_t state;
  cfg_t   cfg;

  logic signed [31:0]        px_r, py_r;
  logic signed [OPND_W-1:0]  zsum_r;
  logic                      clipped_r;
  logic signed [PROD_W-1:0]  xq, yq;
  logic [39:0]               zq_r;
  logic [IDX_W-1:0]          sx, sy;
  logic [15:0]               fx, fy;
  logic [ADDR_W-1:0]         base_r;
  logic [31:0]               acc;

  logic                      accept;
  logic                      ram_we;
  logic [ADDR_W-1:0]         rd_addr;
  logic [15:0]               rdata;
  logic signed [OPND_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [CMP_W-1:0]          gs_ext;
  logic [SIDE_W-1:0]         side_eff, side_m1;
  logic signed [PROD_W-1:0]  lim, lim1;
  logic [ADDR_W-1:0]         side_a, base_c;
  logic [16:0]               fsum, w0, w1, w2;
  logic                      upper;
  logic                      chk_hit;
  logic [1:0]                chk_val;
  logic [31:0]               tz;

  function automatic logic [1:0] border_ans(input logic far_out, input logic clip);
    return (far_out || clip) ? CONT_SOLID : CONT_SKY;
  endfunction

  assign pready = 1'b1;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign ram_we = accept && !opcode && (32'(entry_index) < 32'(DEPTH));

  hpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  hpc_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(entry_index)),
    .wdata (entry_height),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  hpc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // grid side clamp and limits
  always_comb begin
    gs_ext = CMP_W'(cfg.grid_side);
    if (gs_ext < CMP_W'(2)) begin
      side_eff = SIDE_W'(2);
    end else if (gs_ext > CMP_W'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end else begin
      side_eff = SIDE_W'(gs_ext);
    end
    side_m1 = side_eff - SIDE_W'(1);
    lim     = $signed({{(PROD_W-SIDE_W-24){1'b0}}, side_eff, 24'b0});
    lim1    = $signed({{(PROD_W-SIDE_W-24){1'b0}}, side_m1, 24'b0});
    side_a  = ADDR_W'(side_eff);
  end

  // triangle choice and weights
  always_comb begin
    fsum  = {1'b0, fx} + {1'b0, fy};
    upper = fsum > ONE_Q16;
    w0    = upper ? ONE_Q16 - {1'b0, fx} : {1'b0, fy};
    w1    = upper ? ONE_Q16 - {1'b0, fy} : {1'b0, fx};
    w2    = upper ? fsum - ONE_Q16 : ONE_Q16 - fsum;
  end

  assign base_c = prod[ADDR_W-1:0] + ADDR_W'(sx);
  assign tz     = acc + prod[31:0];

  // multiplier operands and read address
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    rd_addr = base_r;
    unique case (state)
      S_MX: begin
        mul_a = $signed({px_r[31], px_r});
        mul_b = $signed({1'b0, cfg.recip_grid});
      end
      S_MY: begin
        mul_a = $signed({py_r[31], py_r});
        mul_b = $signed({1'b0, cfg.recip_grid});
      end
      S_MZ: begin
        mul_a = zsum_r;
        mul_b = $signed({1'b0, cfg.recip_height});
      end
      S_ROW: begin
        mul_a = $signed({{(OPND_W-IDX_W){1'b0}}, sy});
        mul_b = $signed({{(OPND_W-SIDE_W){1'b0}}, side_eff});
      end
      S_RD0: begin
        rd_addr = base_c + side_a;
      end
      S_M0: begin
        mul_a   = $signed({17'b0, rdata});
        mul_b   = $signed({16'b0, w0});
        rd_addr = base_r + ADDR_W'(1);
      end
      S_M1: begin
        mul_a   = $signed({17'b0, rdata});
        mul_b   = $signed({16'b0, w1});
        rd_addr = upper ? base_r + side_a + ADDR_W'(1) : base_r;
      end
      S_M2: begin
        mul_a = $signed({17'b0, rdata});
        mul_b = $signed({16'b0, w2});
      end
      default: ;
    endcase
  end

  // range checks on the scaled point, z product arriving now
  always_comb begin
    chk_hit = 1'b1;
    chk_val = CONT_EMPTY;
    priority if (prod < 0) begin
      chk_val = CONT_SOLID;
    end else if (prod > SKY_LIM_Q24) begin
      chk_val = border_ans(prod > FAR_LIM_Q24, clipped_r);
    end else if (xq < 0) begin
      chk_val = border_ans(xq <= NEG_ONE_Q24, clipped_r);
    end else if (yq < 0) begin
      chk_val = border_ans(yq <= NEG_ONE_Q24, clipped_r);
    end else if (xq >= lim1) begin
      chk_val = border_ans(xq >= lim, clipped_r);
    end else if (yq >= lim1) begin
      chk_val = border_ans(yq >= lim, clipped_r);
    end else begin
      chk_hit = 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (accept && opcode) state <= S_MX;
        S_MX:   state <= S_MY;
        S_MY:   state <= S_MZ;
        S_MZ:   state <= S_CHK;
        S_CHK: begin
          if (chk_hit) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_ROW;
          end
        end
        S_ROW:  state <= S_RD0;
        S_RD0:  state <= S_M0;
        S_M0:   state <= S_M1;
        S_M1:   state <= S_M2;
        S_M2:   state <= S_CMP;
        S_CMP: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r      <= pos_x;
      py_r      <= pos_y;
      zsum_r    <= $signed({pos_z[31], pos_z}) + $signed({clip_offset[31], clip_offset});
      clipped_r <= (clip_offset != 32'sd0);
    end
    if (state == S_MY) begin
      xq <= prod;
    end
    if (state == S_MZ) begin
      yq <= prod;
    end
    if (state == S_CHK) begin
      zq_r     <= prod[39:0];
      sx       <= xq[24 +: IDX_W];
      sy       <= yq[24 +: IDX_W];
      fx       <= xq[23:8];
      fy       <= yq[23:8];
      contents <= chk_val;
    end
    if (state == S_RD0) begin
      base_r <= base_c;
    end
    if (state == S_M1) begin
      acc <= prod[31:0];
    end
    if (state == S_M2) begin
      acc <= tz;
    end
    if (state == S_CMP) begin
      contents <= (zq_r <= {tz, 8'b0}) ? CONT_SOLID : CONT_EMPTY;
    end
  end

  `HPC_ASSERT_NEXT(a_query_busy, start && !busy && opcode, busy, "query did not start")
  `HPC_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `HPC_ASSERT_NOW(a_done_idle, done, !busy, "result while sequencer busy")
  `HPC_ASSERT_NOW(a_sky_unclipped, done && contents == CONT_SKY, !clipped_r, "sky with clip")

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for heightfield_point_classifier_unit: directed and random traffic
`timescale 1ns / 1ps

module testbench;
  import hpc_pkg::*;

  localparam int MAX_SIDE = 256;
  localparam bit OP_WRITE = 1'b0;
  localparam bit OP_QUERY = 1'b1;
  localparam longint ONE_Q24 = longint'(1) << 24;
  localparam logic [63:0] SKY_TOP_Q24 = 64'd65535 << 24;
  localparam logic [63:0] FAR_TOP_Q24 = 64'd65599 << 24;
  // world units per grid step and per height step under the reset scales
  localparam int RST_CELL = 16384;
  localparam int RST_HSTEP = 16;
  localparam int MID = RST_CELL / 2;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic start;
  logic busy;
  logic opcode;
  logic [15:0] entry_index;
  logic [15:0] entry_height;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] clip_offset;
  logic done;
  logic [1:0] contents;

  logic [GRID_W-1:0] cfg_side = GRID_SIDE_RST;
  logic [SCALE_W-1:0] cfg_grid_recip = RECIP_GRID_RST;
  logic [SCALE_W-1:0] cfg_height_recip = RECIP_HEIGHT_RST;
  bit [15:0] height_mem [0:65535];
  bit height_known [0:65535];
  logic [1:0] contents_due [$];
  logic [1:0] due_now;
  int unsigned idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned sent_count = 0;

  heightfield_point_classifier_unit #(
    .MAX_SIDE(MAX_SIDE)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .entry_index(entry_index),
    .entry_height(entry_height),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .clip_offset(clip_offset),
    .done(done),
    .contents(contents)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("heightfield_point_classifier_unit regression: fail");
    $finish;
  end

  function automatic int unsigned eff_side();
    if (cfg_side < 2) return 2;
    if (cfg_side > MAX_SIDE) return MAX_SIDE;
    return 32'(cfg_side);
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic logic [1:0] edge_answer(bit far, bit clipped);
    return (far || clipped) ? CONT_SOLID : CONT_SKY;
  endfunction

  function automatic logic [1:0] classify_point(input logic signed [31:0] px, py, pz, clip,
                                                output bit reads, output int unsigned base);
    longint xq, yq, zsum, lim1, lim;
    logic [63:0] zmag, zq, tz, h00, h10, h01, h11;
    int unsigned side, sx, sy, fx, fy;
    bit clipped;
    reads = 1'b0;
    base = 0;
    side = eff_side();
    clipped = (clip != 0);
    xq = longint'(px) * longint'({32'd0, cfg_grid_recip});
    yq = longint'(py) * longint'({32'd0, cfg_grid_recip});
    zsum = longint'(pz) + longint'(clip);
    zmag = (zsum < 0) ? 64'(-zsum) : 64'(zsum);
    zq = zmag * {32'd0, cfg_height_recip};
    lim1 = longint'(side - 1) << 24;
    lim = longint'(side) << 24;
    if (zsum < 0 && zq != 0) return CONT_SOLID;
    if (zq > SKY_TOP_Q24) return edge_answer(zq > FAR_TOP_Q24, clipped);
    if (xq < 0) return edge_answer(xq <= -ONE_Q24, clipped);
    if (yq < 0) return edge_answer(yq <= -ONE_Q24, clipped);
    if (xq >= lim1) return edge_answer(xq >= lim, clipped);
    if (yq >= lim1) return edge_answer(yq >= lim, clipped);
    sx = 32'(xq >> 24);
    sy = 32'(yq >> 24);
    fx = 32'((xq & 64'hFFFFFF) >> 8);
    fy = 32'((yq & 64'hFFFFFF) >> 8);
    base = sx + sy * side;
    reads = 1'b1;
    h00 = 64'(height_mem[16'(base)]);
    h10 = 64'(height_mem[16'(base + 1)]);
    h01 = 64'(height_mem[16'(base + side)]);
    h11 = 64'(height_mem[16'(base + side + 1)]);
    if (fx + fy > ONE_Q16)
      tz = h01 * (ONE_Q16 - fx) + h11 * (fx + fy - ONE_Q16) + h10 * (ONE_Q16 - fy);
    else
      tz = h01 * fy + h10 * fx + h00 * (ONE_Q16 - fx - fy);
    return (zq <= (tz << 8)) ? CONT_SOLID : CONT_EMPTY;
  endfunction

  // mostly inside the grid, some near its edges, some anywhere
  function automatic logic signed [31:0] pick_axis();
    longint lim1, target, recip;
    int unsigned pick;
    recip = longint'({32'd0, cfg_grid_recip});
    lim1 = longint'(eff_side() - 1) << 24;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom;
    if (pick < 35) begin
      case ($urandom_range(3))
        0: target = -ONE_Q24;
        1: target = 0;
        2: target = lim1;
        default: target = lim1 + ONE_Q24;
      endcase
      return sat32(target / recip + longint'($urandom_range(64)) - 32);
    end
    target = (longint'({32'd0, $urandom}) * (lim1 >>> 24)) >>> 8;
    return sat32(target / recip);
  endfunction

  function automatic void pick_depth(output logic signed [31:0] pz, clip);
    longint target, recip;
    recip = longint'({32'd0, cfg_height_recip});
    case ($urandom_range(19))
      0, 1, 2: target = -longint'($urandom_range(1 << 20));
      3, 4, 5: target = (longint'($urandom_range(65610, 65530)) << 24)
                        + longint'($urandom_range(24'hFFFFFF));
      default: target = (longint'($urandom_range(65535)) << 24)
                        + longint'($urandom_range(24'hFFFFFF));
    endcase
    case ($urandom_range(3))
      0: clip = $urandom;
      1: clip = $urandom_range(512) - 256;
      default: clip = 0;
    endcase
    if ($urandom_range(9) == 0)
      pz = $urandom;
    else
      pz = sat32(target / recip - longint'(clip));
  endfunction

  task automatic note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", what);
  endtask

  // result transfer check
  always @(posedge clk) begin
    if (!rst && done) begin
      if (contents_due.size() == 0) begin
        note_mismatch($sformatf("contents %0d with no query outstanding", contents));
      end else begin
        due_now = contents_due.pop_front();
        if (contents !== due_now)
          note_mismatch($sformatf("contents expected %0d got %0d", due_now, contents));
      end
    end
  end

  task automatic send_item(bit op, logic [15:0] idx, hgt,
                           logic signed [31:0] px, py, pz, clip);
    bit reads;
    int unsigned base;
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    start = 1'b1;
    opcode = op;
    entry_index = idx;
    entry_height = hgt;
    pos_x = px;
    pos_y = py;
    pos_z = pz;
    clip_offset = clip;
    do @(posedge clk); while (busy);
    sent_count++;
    if (op == OP_WRITE) begin
      height_mem[idx] = hgt;
      height_known[idx] = 1'b1;
    end else begin
      contents_due.push_back(classify_point(px, py, pz, clip, reads, base));
    end
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_write(logic [15:0] idx, hgt);
    send_item(OP_WRITE, idx, hgt, $urandom, $urandom, $urandom, $urandom);
  endtask

  // cell corners that were never written get a height first
  task automatic send_query(logic signed [31:0] px, py, pz, clip);
    bit reads;
    int unsigned base, side;
    int unsigned corner [4];
    side = eff_side();
    void'(classify_point(px, py, pz, clip, reads, base));
    if (reads) begin
      corner = '{base, base + 1, base + side, base + side + 1};
      foreach (corner[k])
        if (!height_known[16'(corner[k])]) send_write(16'(corner[k]), 16'($urandom));
    end
    send_item(OP_QUERY, 16'($urandom), 16'($urandom), px, py, pz, clip);
  endtask

  task automatic settle();
    while (contents_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t which, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {which, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (which)
      REG_GRID_SIDE: cfg_side = value[GRID_W-1:0];
      REG_RECIP_GRID: cfg_grid_recip = value;
      default: cfg_height_recip = value;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic test_height_writes();
    send_write(16'd0, 16'd100);
    send_write(16'd1, 16'd200);
    send_write(16'd256, 16'd300);
    send_write(16'd257, 16'd400);
    send_write(16'hFFFF, 16'hFFFF);
    send_write(16'h5A5A, 16'h0000);
  endtask

  task automatic test_vertical_bands();
    send_query(MID, MID, -1, 0);
    send_query(MID, MID, 0, 0);
    send_query(MID, MID, 65535 * RST_HSTEP, 0);
    send_query(MID, MID, 65535 * RST_HSTEP + 1, 0);
    send_query(MID, MID, 65599 * RST_HSTEP, 0);
    send_query(MID, MID, 65599 * RST_HSTEP + 1, 0);
    send_query(MID, MID, 65535 * RST_HSTEP - 4, 5);
    send_query(MID, MID, 32'sh80000000, 32'sh80000000);
  endtask

  task automatic test_grid_edges();
    send_query(-1, MID, 1000, 0);
    send_query(-RST_CELL, MID, 1000, 0);
    send_query(MID, -1, 1000, 0);
    send_query(MID, -RST_CELL, 1000, 0);
    send_query(255 * RST_CELL, MID, 1000, 0);
    send_query(256 * RST_CELL, MID, 1000, 0);
    send_query(MID, 256 * RST_CELL - 1, 1000, 0);
    send_query(-1, MID, 999, 1);
  endtask

  task automatic test_triangle_split();
    send_query(0, 0, 100 * RST_HSTEP, 0);
    send_query(0, 0, 100 * RST_HSTEP + 1, 0);
    send_query(3 * RST_CELL / 4, 3 * RST_CELL / 4, 325 * RST_HSTEP, 0);
    send_query(3 * RST_CELL / 4, 3 * RST_CELL / 4, 325 * RST_HSTEP + 1, 0);
    send_query(255 * RST_CELL - 1, 255 * RST_CELL - 1, 0, 0);
  endtask

  task automatic test_side_clamp();
    settle();
    write_reg(REG_GRID_SIDE, 0);
    send_query(RST_CELL - 1, MID, 1000, 0);
    settle();
    write_reg(REG_GRID_SIDE, 1);
    send_query(RST_CELL, MID, 1000, 0);
    settle();
    write_reg(REG_GRID_SIDE, 511);
    send_query(256 * RST_CELL, MID, 1000, 0);
  endtask

  // count covers every transfer, corner fills included
  task automatic run_traffic(int unsigned side, gscale, hscale, pct, count);
    logic signed [31:0] px, py, pz, clip;
    int unsigned stop_at;
    settle();
    write_reg(REG_GRID_SIDE, side);
    write_reg(REG_RECIP_GRID, gscale);
    write_reg(REG_RECIP_HEIGHT, hscale);
    idle_pct = pct;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      if ($urandom_range(99) < 15) begin
        send_write(16'($urandom), 16'($urandom));
      end else begin
        px = pick_axis();
        py = pick_axis();
        pick_depth(pz, clip);
        send_query(px, py, pz, clip);
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned pcts [3] = '{0, 88, 9};
    run_traffic(256, 1024, 1048576, 0, 150);
    run_traffic(2, 65536, 65536, 88, 150);
    run_traffic(0, $urandom_range(1 << 20, 256), $urandom_range(1 << 22, 4096), 9, 150);
    run_traffic(511, 32'hFFFFFFFF, 1, 0, 100);
    run_traffic(1, 1, 32'hFFFFFFFF, 88, 100);
    for (int k = 0; k < 5; k++)
      run_traffic($urandom_range(256, 2), $urandom_range(1 << 20, 256),
                  $urandom_range(1 << 22, 4096), pcts[k % 3], 100);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    opcode = OP_WRITE;
    entry_index = '0;
    entry_height = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    clip_offset = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_height_writes();
    test_vertical_bands();
    test_grid_edges();
    test_triangle_split();
    test_side_clamp();
    test_random_traffic();
    while (contents_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("heightfield_point_classifier_unit regression: pass");
    else
      $display("heightfield_point_classifier_unit regression: fail");
    $finish;
  end

endmodule
